// ===== design/rrpt_pkg.sv =====
// Shared types, constants and helpers for the reassembly range playout tracker.
package rrpt_pkg;

    // Table depth (head range included) and internal offset width.
    localparam int MAX_RANGES  = 16;
    localparam int OFFSET_BITS = 32;

    // Derived widths.
    localparam int COUNT_W       = $clog2(MAX_RANGES + 1);
    localparam int PORT_W        = 32;
    localparam int COUNT_PORT_W  = 5;
    localparam int PADDR_W       = 4;
    localparam int REG_IDX_W     = 2;

    // Input mode codes.
    localparam logic MODE_DATA = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef logic [OFFSET_BITS-1:0] offset_t;
    typedef logic [COUNT_W-1:0]     count_t;

    // Configuration register indexes.
    typedef enum logic [REG_IDX_W-1:0] {
        REG_CONTENT_SIZE = 2'd0,
        REG_CONSUME_RATE = 2'd1,
        REG_PREBUFFER    = 2'd2
    } reg_idx_t;

    // Operations broadcast to the row of range cells.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOWER,
        OP_INSERT,
        OP_SHIFT
    } cell_op_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_PROBE,
        ST_PLACE,
        ST_MERGE,
        ST_FINISH
    } state_t;

    // One stored byte range.
    typedef struct packed {
        offset_t start;
        offset_t stop;
    } range_t;

    // Command to the cells: operation plus the incoming range bounds.
    typedef struct packed {
        cell_op_t op;
        offset_t  lo;
        offset_t  hi;
    } cell_cmd_t;

    typedef struct packed {
        offset_t content_size;
        offset_t consume_rate;
        offset_t prebuffer_bytes;
    } cfg_t;

    typedef struct packed {
        logic    mode;
        offset_t range_end;
        offset_t range_bytes;
        logic    burst_last;
    } item_t;

    typedef struct packed {
        offset_t available_offset;
        offset_t consumed_offset;
        count_t  range_count;
        logic    ack_request;
        logic    play_started;
        logic    all_received;
        logic    stalled;
        logic    resumed;
        logic    table_full;
    } result_t;

    // Controller status seen by the cell row.
    typedef struct packed {
        count_t  used;
        offset_t avail;
    } status_t;

    // True when avail is at or above pos by at least rate bytes.
    function automatic logic room_ok(offset_t avail, offset_t pos, offset_t rate);
        logic [OFFSET_BITS:0] diff;
        diff = {1'b0, avail} - {1'b0, pos};
        return !diff[OFFSET_BITS] && (diff[OFFSET_BITS-1:0] >= rate);
    endfunction

endpackage

// ===== design/rrpt_cell.sv =====
// One cell of the range table: holds a range and trades it with its neighbors.
module rrpt_cell import rrpt_pkg::*; (
    input  logic      clk,
    input  cell_cmd_t cmd,
    input  logic      valid,
    input  logic      left_before,
    input  range_t    left_entry,
    input  range_t    right_entry,
    output range_t    entry,
    output logic      ends_below,
    output logic      hit
);

    range_t entry_reg;
    range_t entry_next;
    logic   at_slot;

    // This cell ends before the new range; the first cell that does not is the slot.
    always_comb
    begin
        ends_below = valid && (entry_reg.stop < cmd.lo);
        at_slot    = left_before && !ends_below;
        hit        = at_slot && valid && (entry_reg.start <= cmd.hi);
    end

    // Per-cell update for the broadcast operation.
    always_comb
    begin
        entry_next = entry_reg;
        unique case (cmd.op)
            OP_HOLD:
            begin
                entry_next = entry_reg;
            end
            OP_LOWER:
            begin
                if (hit && (entry_reg.start > cmd.lo))
                begin
                    entry_next.start = cmd.lo;
                end
            end
            OP_INSERT:
            begin
                if (at_slot)
                begin
                    entry_next.start = cmd.lo;
                    entry_next.stop  = cmd.hi;
                end
                else if (!left_before)
                begin
                    entry_next = left_entry;
                end
            end
            OP_SHIFT:
            begin
                entry_next = right_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== design/rrpt_ctrl.sv =====
// Sequencer for the tracker: head range, table count, playout state and result beat.
module rrpt_ctrl import rrpt_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  item_t     item,
    input  cfg_t      cfg,
    input  logic      hit_any,
    input  range_t    first_entry,
    output cell_cmd_t cmd,
    output status_t   status,
    output logic      result_valid,
    input  logic      result_stall,
    output result_t   result
);

    state_t  state_reg, state_next;
    count_t  used_reg, used_next;
    offset_t avail_reg, avail_next;
    offset_t pos_reg, pos_next;
    logic    playing_reg, playing_next;
    logic    pending_reg, pending_next;
    logic    hit_reg, hit_next;
    logic    full_reg, full_next;
    logic    stalled_reg, stalled_next;
    logic    res_valid_reg, res_valid_next;

    logic    tick_reg, tick_next;
    logic    last_reg, last_next;
    offset_t lo_reg, lo_next;
    offset_t hi_reg, hi_next;
    result_t res_reg, res_next;

    logic    accept;
    logic    res_load;
    logic    can_merge;
    logic    ahead;
    logic    extend;
    logic    room;
    logic    resumed_now;
    logic    started_now;
    logic    ack_now;

    // Comparisons shared by next-state and datapath logic.
    always_comb
    begin
        can_merge   = (used_reg > COUNT_W'(1)) && (avail_reg >= first_entry.start);
        ahead       = lo_reg > avail_reg;
        extend      = (hi_reg > avail_reg) || (lo_reg == avail_reg);
        room        = room_ok(avail_reg, pos_reg, cfg.consume_rate);
        resumed_now = !tick_reg && pending_reg && room;
        started_now = !tick_reg && last_reg && (avail_reg > cfg.prebuffer_bytes)
                      && !playing_reg;
        ack_now     = !tick_reg && last_reg && (avail_reg < cfg.content_size);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (tick_reg)
                begin
                    state_next = ST_FINISH;
                end
                else if (ahead)
                begin
                    state_next = ST_PROBE;
                end
                else if (extend)
                begin
                    state_next = ST_MERGE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_PROBE:
            begin
                state_next = ST_PLACE;
            end
            ST_PLACE:
            begin
                state_next = ST_FINISH;
            end
            ST_MERGE:
            begin
                if (!can_merge)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (res_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs: handshake, cell command, result load.
    always_comb
    begin
        item_stall = 1'b1;
        accept     = 1'b0;
        res_load   = 1'b0;
        cmd.op     = OP_HOLD;
        cmd.lo     = lo_reg;
        cmd.hi     = hi_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                accept     = item_valid;
            end
            ST_PLACE:
            begin
                if (hit_reg)
                begin
                    cmd.op = OP_LOWER;
                end
                else if (!full_reg)
                begin
                    cmd.op = OP_INSERT;
                end
            end
            ST_MERGE:
            begin
                if (can_merge)
                begin
                    cmd.op = OP_SHIFT;
                end
            end
            ST_FINISH:
            begin
                res_load = !res_valid_reg || !result_stall;
            end
            default:
            begin
                cmd.op = OP_HOLD;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        used_next    = used_reg;
        avail_next   = avail_reg;
        pos_next     = pos_reg;
        playing_next = playing_reg;
        pending_next = pending_reg;
        hit_next     = hit_reg;
        full_next    = full_reg;
        stalled_next = stalled_reg;
        tick_next    = tick_reg;
        last_next    = last_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        res_next     = res_reg;

        // Capture the beat; the start offset saturates at zero.
        if (accept)
        begin
            tick_next    = (item.mode == MODE_TICK);
            last_next    = item.burst_last;
            hi_next      = item.range_end;
            lo_next      = (item.range_bytes > item.range_end) ? '0
                           : item.range_end - item.range_bytes;
            hit_next     = 1'b0;
            full_next    = 1'b0;
            stalled_next = 1'b0;
        end

        // Playout tick, or head extension for a range that reaches the head.
        if (state_reg == ST_DECIDE)
        begin
            if (tick_reg)
            begin
                if (playing_reg && (pos_reg < cfg.content_size))
                begin
                    if (room)
                    begin
                        pos_next = pos_reg + cfg.consume_rate;
                    end
                    else
                    begin
                        pos_next = avail_reg;
                        if (avail_reg < cfg.content_size)
                        begin
                            pending_next = 1'b1;
                            stalled_next = 1'b1;
                        end
                    end
                end
            end
            else if (!ahead && extend)
            begin
                avail_next = hi_reg;
            end
        end

        // Slot search result from the cell row.
        if (state_reg == ST_PROBE)
        begin
            hit_next  = hit_any;
            full_next = !hit_any && (used_reg == COUNT_W'(MAX_RANGES));
        end

        if ((state_reg == ST_PLACE) && !hit_reg && !full_reg)
        begin
            used_next = used_reg + COUNT_W'(1);
        end

        // Absorb the first stored range into the head.
        if ((state_reg == ST_MERGE) && can_merge)
        begin
            avail_next = (first_entry.stop > avail_reg) ? first_entry.stop : avail_reg;
            used_next  = used_reg - COUNT_W'(1);
        end

        // Build the result beat and update the playout flags.
        if (res_load)
        begin
            if (resumed_now)
            begin
                pending_next = 1'b0;
            end
            if (started_now)
            begin
                playing_next = 1'b1;
            end
            res_next.available_offset = avail_reg;
            res_next.consumed_offset  = pos_reg;
            res_next.range_count      = used_reg;
            res_next.ack_request      = ack_now;
            res_next.play_started     = started_now;
            res_next.all_received     = (avail_reg == cfg.content_size);
            res_next.stalled          = stalled_reg;
            res_next.resumed          = resumed_now;
            res_next.table_full       = full_reg;
        end
    end

    // Result beat valid: set on load, cleared when taken.
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= COUNT_W'(1);
            avail_reg     <= '0;
            pos_reg       <= '0;
            playing_reg   <= 1'b0;
            pending_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            full_reg      <= 1'b0;
            stalled_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            avail_reg     <= avail_next;
            pos_reg       <= pos_next;
            playing_reg   <= playing_next;
            pending_reg   <= pending_next;
            hit_reg       <= hit_next;
            full_reg      <= full_next;
            stalled_reg   <= stalled_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Beat payload.
    always_ff @(posedge clk)
    begin
        tick_reg <= tick_next;
        last_reg <= last_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        res_reg  <= res_next;
    end

    assign status.used   = used_reg;
    assign status.avail  = avail_reg;
    assign result_valid  = res_valid_reg;
    assign result        = res_reg;

endmodule

// ===== design/reassembly_range_playout_tracker.sv =====
// Top level of the reassembly range playout tracker: register port, cell row, sequencer.
//
// Input beats carry either a received byte range (mode 0: range_end, range_bytes,
// burst_last) or a playout tick (mode 1). Each accepted beat yields exactly one
// result beat with the contiguous available offset, the playout position, the
// number of stored ranges and the event flags.
// Both channels move a beat when valid is high and stall is low. The block works
// on one beat at a time: item_stall is high from acceptance until the result is
// written into the output register, which frees the input side while the result
// waits downstream.
// A tick or a stale range goes from ST_DECIDE to ST_FINISH; a range placed ahead
// of the head passes ST_PROBE and ST_PLACE; a range that extends the head stays in
// ST_MERGE while stored ranges merge into it, one shift of the cell row per cycle.
// The next beat is taken only once the previous one has left ST_FINISH, so the merge
// walk sets the worst case.
// If the result register is still full and stalled, the sequencer holds the
// finished beat until the register frees.
// Reset empties the table to the head range [0, 0), stops playout and loads the
// register defaults; the configuration registers are to be written over the APB port
// only while no beat is in flight, which the block itself does not enforce.
module reassembly_range_playout_tracker import rrpt_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [PADDR_W-1:0]      paddr,
    input  logic [PORT_W-1:0]       pwdata,
    output logic [PORT_W-1:0]       prdata,
    output logic                    pready,
    input  logic                    item_valid,
    output logic                    item_stall,
    input  logic                    mode,
    input  logic [PORT_W-1:0]       range_end,
    input  logic [PORT_W-1:0]       range_bytes,
    input  logic                    burst_last,
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic [PORT_W-1:0]       available_offset,
    output logic [PORT_W-1:0]       consumed_offset,
    output logic [COUNT_PORT_W-1:0] range_count,
    output logic                    ack_request,
    output logic                    play_started,
    output logic                    all_received,
    output logic                    stalled,
    output logic                    resumed,
    output logic                    table_full
);

    cfg_t      cfg_reg, cfg_next;
    reg_idx_t  reg_idx;
    logic      cfg_write;
    item_t     item;
    cell_cmd_t cmd;
    status_t   status;
    result_t   result;
    logic      hit_any;

    range_t                  entry_w [1:MAX_RANGES-1];
    logic [MAX_RANGES-1:1]   before_w;
    logic [MAX_RANGES-1:1]   hit_w;

    // Register port decode.
    assign reg_idx   = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_idx)
                REG_CONTENT_SIZE: cfg_next.content_size    = OFFSET_BITS'(pwdata);
                REG_CONSUME_RATE: cfg_next.consume_rate    = OFFSET_BITS'(pwdata);
                REG_PREBUFFER:    cfg_next.prebuffer_bytes = OFFSET_BITS'(pwdata);
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_CONTENT_SIZE: prdata = PORT_W'(cfg_reg.content_size);
            REG_CONSUME_RATE: prdata = PORT_W'(cfg_reg.consume_rate);
            REG_PREBUFFER:    prdata = PORT_W'(cfg_reg.prebuffer_bytes);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.content_size    <= '0;
            cfg_reg.consume_rate    <= OFFSET_BITS'(1);
            cfg_reg.prebuffer_bytes <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Input beat in the internal offset width.
    assign item.mode        = mode;
    assign item.range_end   = OFFSET_BITS'(range_end);
    assign item.range_bytes = OFFSET_BITS'(range_bytes);
    assign item.burst_last  = burst_last;

    // Row of range cells behind the head; cell k holds table entry k.
    for (genvar k = 1; k < MAX_RANGES; k++)
    begin : g_cell
        logic   valid;
        logic   left_before;
        range_t left_entry;
        range_t right_entry;

        assign valid = (status.used > COUNT_W'(k));

        if (k == 1)
        begin : g_first
            assign left_before      = 1'b1;
            assign left_entry.start = '0;
            assign left_entry.stop  = status.avail;
        end
        else
        begin : g_inner
            assign left_before = before_w[k-1];
            assign left_entry  = entry_w[k-1];
        end

        if (k == MAX_RANGES - 1)
        begin : g_last
            assign right_entry = entry_w[k];
        end
        else
        begin : g_chain
            assign right_entry = entry_w[k+1];
        end

        rrpt_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .valid       (valid),
            .left_before (left_before),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (entry_w[k]),
            .ends_below  (before_w[k]),
            .hit         (hit_w[k])
        );
    end

    assign hit_any = |hit_w;

    rrpt_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .cfg          (cfg_reg),
        .hit_any      (hit_any),
        .first_entry  (entry_w[1]),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Result beat to the ports.
    assign available_offset = PORT_W'(result.available_offset);
    assign consumed_offset  = PORT_W'(result.consumed_offset);
    assign range_count      = COUNT_PORT_W'(result.range_count);
    assign ack_request      = result.ack_request;
    assign play_started     = result.play_started;
    assign all_received     = result.all_received;
    assign stalled          = result.stalled;
    assign resumed          = result.resumed;
    assign table_full       = result.table_full;

    // An accepted beat keeps the input side stalled while it is worked on.
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall
    ) else $error("input not stalled after an accepted beat");

    // The contiguous available offset never moves backward.
    a_avail_monotonic: assert property (
        @(posedge clk) disable iff (!rst_n)
        status.avail >= $past(status.avail)
    ) else $error("available offset decreased");

    // The table always holds the head and never more than its depth.
    a_used_bounds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (status.used >= COUNT_W'(1)) && (status.used <= COUNT_W'(MAX_RANGES))
    ) else $error("range count out of bounds");

    // A stall report only comes from a tick, which raises no data-side flag.
    a_flag_modes: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid && stalled) |->
            !(ack_request || play_started || resumed || table_full)
    ) else $error("stall reported together with a data-side flag");

endmodule

// ===== sim/rrpt_checker.sv =====
// Checker for the reassembly range playout tracker: predicts each result beat and compares it.
`timescale 1ns / 100ps

module rrpt_checker import rrpt_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [PADDR_W-1:0]      paddr,
    input  logic [PORT_W-1:0]       pwdata,
    input  logic                    pready,
    input  logic                    item_valid,
    input  logic                    item_stall,
    input  logic                    mode,
    input  logic [PORT_W-1:0]       range_end,
    input  logic [PORT_W-1:0]       range_bytes,
    input  logic                    burst_last,
    input  logic                    result_valid,
    input  logic                    result_stall,
    input  logic [PORT_W-1:0]       available_offset,
    input  logic [PORT_W-1:0]       consumed_offset,
    input  logic [COUNT_PORT_W-1:0] range_count,
    input  logic                    ack_request,
    input  logic                    play_started,
    input  logic                    all_received,
    input  logic                    stalled,
    input  logic                    resumed,
    input  logic                    table_full,
    output int                      pending_results,
    output int                      mismatch_count
);

    // Shadow copy of the configuration registers.
    offset_t cfg_content;
    offset_t cfg_rate;
    offset_t cfg_prebuffer;

    // Shadow copy of the range table and the playout state.
    offset_t seg_lo [MAX_RANGES];
    offset_t seg_hi [MAX_RANGES];
    int      seg_used;
    offset_t play_pos;
    bit      is_playing;
    bit      dry_pending;

    // Results still owed by the block, oldest first.
    result_t status_owed_q [$];
    result_t want;
    int      errors;
    int      results_seen;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        errors++;
        $display("[%0t] result beat %0d: %s is 0x%08h, predicted 0x%08h",
                 $time, results_seen, what, got, exp_val);
    endtask

    task automatic compare_field(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
        if (got !== exp_val)
            report_mismatch(what, got, exp_val);
    endtask

    // Apply one input beat to the shadow table and work out the status it reports.
    task automatic track_segment(input logic m, input offset_t end_off, input offset_t len,
                                 input logic last, output result_t r);
        offset_t lo;
        offset_t head;
        int      i;
        int      k;
        r = '0;
        if (m == MODE_DATA) begin
            lo = (len > end_off) ? '0 : end_off - len;
            head = seg_hi[0];
            if (lo > head) begin
                // Find the first stored range that reaches the new start.
                i = 0;
                while (i < seg_used && seg_hi[i] < lo)
                    i++;
                if (i == seg_used || seg_lo[i] > end_off) begin
                    if (seg_used >= MAX_RANGES) begin
                        r.table_full = 1'b1;
                    end
                    else begin
                        for (k = seg_used; k > i; k--) begin
                            seg_lo[k] = seg_lo[k - 1];
                            seg_hi[k] = seg_hi[k - 1];
                        end
                        seg_lo[i] = lo;
                        seg_hi[i] = end_off;
                        seg_used++;
                    end
                end
                else if (seg_lo[i] > lo) begin
                    // Overlap from below only pulls the stored start down.
                    seg_lo[i] = lo;
                end
            end
            else if (end_off > head || lo == head) begin
                seg_hi[0] = end_off;
                // Fold following ranges into the head while they touch it.
                while (seg_used > 1 && seg_hi[0] >= seg_lo[1]) begin
                    if (seg_hi[0] < seg_hi[1])
                        seg_hi[0] = seg_hi[1];
                    for (k = 1; k + 1 < seg_used; k++) begin
                        seg_lo[k] = seg_lo[k + 1];
                        seg_hi[k] = seg_hi[k + 1];
                    end
                    seg_used--;
                end
            end
            head = seg_hi[0];
            if (dry_pending && head >= play_pos && head - play_pos >= cfg_rate) begin
                dry_pending = 1'b0;
                r.resumed = 1'b1;
            end
            if (last) begin
                if (head > cfg_prebuffer && !is_playing) begin
                    is_playing = 1'b1;
                    r.play_started = 1'b1;
                end
                if (head < cfg_content)
                    r.ack_request = 1'b1;
            end
        end
        else begin
            head = seg_hi[0];
            if (is_playing && play_pos < cfg_content) begin
                if (head >= play_pos && head - play_pos >= cfg_rate) begin
                    play_pos = play_pos + cfg_rate;
                end
                else begin
                    // Playout ran dry: it stops at the available offset.
                    play_pos = head;
                    if (play_pos < cfg_content) begin
                        dry_pending = 1'b1;
                        r.stalled = 1'b1;
                    end
                end
            end
        end
        r.available_offset = seg_hi[0];
        r.consumed_offset  = play_pos;
        r.range_count      = count_t'(seg_used);
        r.all_received     = (seg_hi[0] == cfg_content);
    endtask

    // Watch the register port and both channels.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_content   = '0;
            cfg_rate      = offset_t'(1);
            cfg_prebuffer = '0;
            for (int k = 0; k < MAX_RANGES; k++) begin
                seg_lo[k] = '0;
                seg_hi[k] = '0;
            end
            seg_used    = 1;
            play_pos    = '0;
            is_playing  = 1'b0;
            dry_pending = 1'b0;
            status_owed_q.delete();
            pending_results <= 0;
            mismatch_count  <= errors;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[PADDR_W-1:2]))
                    REG_CONTENT_SIZE: cfg_content   = pwdata;
                    REG_CONSUME_RATE: cfg_rate      = pwdata;
                    REG_PREBUFFER:    cfg_prebuffer = pwdata;
                    default: ;
                endcase
            end
            if (item_valid && !item_stall) begin
                track_segment(mode, range_end, range_bytes, burst_last, want);
                status_owed_q = {status_owed_q, want};
            end
            if (result_valid && !result_stall) begin
                results_seen++;
                if (status_owed_q.size() == 0) begin
                    report_mismatch("unexpected beat, available_offset", available_offset, '0);
                end
                else begin
                    want = status_owed_q.pop_front();
                    compare_field("available_offset", available_offset, want.available_offset);
                    compare_field("consumed_offset", consumed_offset, want.consumed_offset);
                    compare_field("range_count", 32'(range_count), 32'(want.range_count));
                    compare_field("ack_request", 32'(ack_request), 32'(want.ack_request));
                    compare_field("play_started", 32'(play_started), 32'(want.play_started));
                    compare_field("all_received", 32'(all_received), 32'(want.all_received));
                    compare_field("stalled", 32'(stalled), 32'(want.stalled));
                    compare_field("resumed", 32'(resumed), 32'(want.resumed));
                    compare_field("table_full", 32'(table_full), 32'(want.table_full));
                end
            end
            pending_results <= status_owed_q.size();
            mismatch_count  <= errors;
        end
    end

endmodule

// ===== sim/tb_reassembly_range_playout_tracker.sv =====
// Testbench top for the reassembly range playout tracker: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_reassembly_range_playout_tracker;
    import rrpt_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 400;
    localparam int SETTLE_CYCLES  = MAX_RANGES + 4;

    logic                    clk;
    logic                    rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [PADDR_W-1:0]      paddr;
    logic [PORT_W-1:0]       pwdata;
    logic [PORT_W-1:0]       prdata;
    logic                    pready;
    logic                    item_valid;
    logic                    item_stall;
    logic                    mode;
    logic [PORT_W-1:0]       range_end;
    logic [PORT_W-1:0]       range_bytes;
    logic                    burst_last;
    logic                    result_valid;
    logic                    result_stall;
    logic [PORT_W-1:0]       available_offset;
    logic [PORT_W-1:0]       consumed_offset;
    logic [COUNT_PORT_W-1:0] range_count;
    logic                    ack_request;
    logic                    play_started;
    logic                    all_received;
    logic                    stalled;
    logic                    resumed;
    logic                    table_full;
    int                      pending_results;
    int                      mismatch_count;

    // Stimulus bookkeeping shared with the receiver process.
    int      items_sent     = 0;
    int      stuck_cycles   = 0;
    bit      idle_on        = 1'b0;
    bit      quiet          = 1'b0;
    bit      long_hold_req  = 1'b0;
    bit      hold_done      = 1'b0;
    offset_t last_avail     = '0;

    reassembly_range_playout_tracker DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .item_valid       (item_valid),
        .item_stall       (item_stall),
        .mode             (mode),
        .range_end        (range_end),
        .range_bytes      (range_bytes),
        .burst_last       (burst_last),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .available_offset (available_offset),
        .consumed_offset  (consumed_offset),
        .range_count      (range_count),
        .ack_request      (ack_request),
        .play_started     (play_started),
        .all_received     (all_received),
        .stalled          (stalled),
        .resumed          (resumed),
        .table_full       (table_full)
    );

    rrpt_checker u_checker (.*);

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Remember the frontier so each window of new data starts where the last one ended.
    always @(posedge clk) begin
        if (result_valid && !result_stall)
            last_avail <= available_offset;
    end

    // Count cycles in which no beat moves on either channel.
    always @(posedge clk) begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial begin
        wait (stuck_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // Result side: random stall bursts, one long hold-off on request, none at the end.
    initial begin
        result_stall = 1'b0;
        @(posedge clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (idle_on && !quiet && $urandom_range(0, 3) == 0) begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else begin
                result_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    task automatic write_reg(input reg_idx_t idx, input offset_t value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input offset_t content, input offset_t rate,
                             input offset_t prebuffer);
        write_reg(REG_CONTENT_SIZE, content);
        write_reg(REG_CONSUME_RATE, rate);
        write_reg(REG_PREBUFFER, prebuffer);
    endtask

    // Offer one beat and hold it until the block takes it; then maybe pause.
    task automatic send_beat(input logic m, input offset_t end_off, input offset_t len,
                             input logic last);
        item_valid  <= 1'b1;
        mode        <= m;
        range_end   <= end_off;
        range_bytes <= len;
        burst_last  <= last;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        items_sent++;
        if (idle_on && !quiet && $urandom_range(0, 3) == 0) begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    // Let every owed result come back, then give the block time to go idle.
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One window of new content: split into pieces, sent out of order with
    // playout ticks and stray ranges mixed in, closed by a range covering it all.
    task automatic reassemble_window();
        offset_t base;
        offset_t span;
        offset_t cut;
        offset_t piece;
        offset_t tmp_end;
        offset_t tmp_len;
        offset_t piece_end [$];
        offset_t piece_len [$];
        int      n;
        int      a;
        int      b;
        int      kind;
        drain();
        base = last_avail;
        span = $urandom_range(100, 1500);
        kind = $urandom_range(0, 9);
        if (kind == 0)
            configure('0, offset_t'(1), '0);
        else if (kind == 1)
            configure(base + span, '1, '1);
        else
            configure(($urandom_range(0, 4) == 0) ? base + $urandom_range(0, span) : base + span,
                      $urandom_range(1, 40), base + $urandom_range(0, span));
        idle_on = !quiet && ($urandom_range(0, 3) != 0);
        if (!hold_done && !quiet && items_sent > 300) begin
            long_hold_req = 1'b1;
            hold_done = 1'b1;
        end

        cut = base;
        while (cut < base + span) begin
            piece = $urandom_range(1, span / 6);
            if (cut + piece > base + span)
                piece = base + span - cut;
            cut = cut + piece;
            piece_end = {piece_end, cut};
            piece_len = {piece_len, (($urandom_range(0, 4) == 0) ? piece + $urandom_range(1, 40)
                                                                 : piece)};
        end
        n = piece_end.size();
        repeat ($urandom_range(0, n)) begin
            a = $urandom_range(0, n - 1);
            b = $urandom_range(0, n - 1);
            tmp_end = piece_end[a];
            tmp_len = piece_len[a];
            piece_end[a] = piece_end[b];
            piece_len[a] = piece_len[b];
            piece_end[b] = tmp_end;
            piece_len[b] = tmp_len;
        end

        for (a = 0; a < n; a++) begin
            if ($urandom_range(0, 3) == 0)
                send_beat(MODE_TICK, $urandom, $urandom, 1'($urandom_range(0, 1)));
            case ($urandom_range(0, 11))
                // Stale range below the frontier.
                0: send_beat(MODE_DATA, $urandom_range(0, base), $urandom_range(0, 64), 1'b0);
                // Repeat of a piece.
                1: begin
                    b = $urandom_range(0, n - 1);
                    send_beat(MODE_DATA, piece_end[b], piece_len[b], 1'($urandom_range(0, 1)));
                end
                // Length beyond the end offset: the start clamps to zero.
                2: send_beat(MODE_DATA, base + $urandom_range(0, span), '1, 1'b0);
                // Empty range.
                3: send_beat(MODE_DATA, base + $urandom_range(0, span), '0, 1'b0);
                default: ;
            endcase
            send_beat(MODE_DATA, piece_end[a], piece_len[a], $urandom_range(0, 3) == 0);
        end
        send_beat(MODE_DATA, base + span, span, 1'b1);
        repeat ($urandom_range(0, 4))
            send_beat(MODE_TICK, $urandom, $urandom, 1'($urandom_range(0, 1)));
    endtask

    initial begin
        int k;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        item_valid  = 1'b0;
        mode        = MODE_DATA;
        range_end   = '0;
        range_bytes = '0;
        burst_last  = 1'b0;
        rst_n       = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: stale, clamped start, playout start, start lowering, full table.
        configure(1000, 10, 50);
        send_beat(MODE_TICK, 0, 0, 1'b0);
        send_beat(MODE_DATA, 100, 200, 1'b0);
        send_beat(MODE_DATA, 100, 50, 1'b0);
        send_beat(MODE_DATA, 300, 100, 1'b1);
        send_beat(MODE_DATA, 250, 100, 1'b0);
        send_beat(MODE_TICK, '1, '1, 1'b1);
        for (k = 0; k < 15; k++)
            send_beat(MODE_DATA, 320 + 20 * k, 10, 1'b0);
        send_beat(MODE_DATA, 1000, 900, 1'b0);
        send_beat(MODE_TICK, 0, 0, 1'b0);

        // Directed: largest settings, playout runs dry twice, more data arrives.
        drain();
        configure('1, '1, '1);
        send_beat(MODE_TICK, 0, 0, 1'b0);
        send_beat(MODE_TICK, 0, 0, 1'b0);
        send_beat(MODE_DATA, 1200, 200, 1'b1);

        // Random windows of well-formed content; the last ones run without idling.
        while (items_sent < 880) begin
            if (items_sent >= 700) begin
                quiet = 1'b1;
                idle_on = 1'b0;
            end
            reassemble_window();
        end

        // Fully random beats across the whole offset range.
        drain();
        configure($urandom, $urandom | 32'd1, $urandom);
        repeat (70)
            send_beat(($urandom_range(0, 3) == 0) ? MODE_TICK : MODE_DATA, $urandom,
                      ($urandom_range(0, 1) == 1) ? offset_t'($urandom)
                                                  : offset_t'($urandom_range(0, 64)),
                      1'($urandom_range(0, 1)));

        drain();
        if (mismatch_count == 0 && pending_results == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
